/* src/rsts_pkg.sv */
package rsts_pkg;

  // Table geometry and segment limits.
  localparam int unsigned SEGMENTS     = 16;
  localparam int unsigned PAGE_BYTES   = 4096;
  localparam int unsigned REGION_PAGES = 256;
  localparam int unsigned ID_BITS      = 16;

  // Field widths of the request and response words.
  localparam int unsigned OP_W    = 2;
  localparam int unsigned SIZE_W  = 24;
  localparam int unsigned SID_W   = 16;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned EIDX_W  = 4;
  localparam int unsigned PAGES_W = 9;
  localparam int unsigned REFS_W  = 16;

  // Derived constants.
  localparam int unsigned IDX_W      = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned REGION_BYTES = REGION_PAGES * PAGE_BYTES;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE = 2'd0,
    OP_ATTACH = 2'd1,
    OP_DETACH = 2'd2,
    OP_UNLINK = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_SIZE   = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_MARKED     = 3'd4,
    ST_COUNT_FULL = 3'd5
  } status_e;

endpackage

/* src/rsts_if.sv */
interface rsts_req_if;
  import rsts_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [SIZE_W-1:0] size_bytes;
  logic [SID_W-1:0]  seg_id;

  modport source (output valid, op, size_bytes, seg_id, input ready);
  modport sink   (input valid, op, size_bytes, seg_id, output ready);
endinterface

interface rsts_rsp_if;
  import rsts_pkg::*;

  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [SID_W-1:0]   result_id;
  logic [EIDX_W-1:0]  entry_index;
  logic [PAGES_W-1:0] pages;
  logic [REFS_W-1:0]  refs;
  logic               released;

  modport source (output valid, status, result_id, entry_index, pages, refs, released,
                  input ready);
  modport sink   (input valid, status, result_id, entry_index, pages, refs, released,
                  output ready);
endinterface

/* src/refcounted_segment_table_core.sv */
// Channel   Direction  Word
// req_i     in         op, size_bytes, seg_id
// rsp_o     out        status, result_id, entry_index, pages, refs, released
//
// Each request word is held in an input register, where the table lookup and
// update are done; the response is written to an output register at the same
// edge. One word per cycle is sustained while the response side is not stalled.
// A response passes through the input register and then the output register.
// A stalled response holds both registers; req_i.ready drops only when the
// input register is full and cannot move on. Reset clears all used flags and
// sets the next id to one; no clearing pass is needed.
module refcounted_segment_table_core
  import rsts_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  rsts_req_if.sink   req_i,
  rsts_rsp_if.source rsp_o
);

  localparam logic [ID_BITS-1:0] ID_MAX   = {ID_BITS{1'b1}};
  localparam logic [REFS_W-1:0]  REFS_MAX = {REFS_W{1'b1}};

  // Input register.
  logic              s_valid_q;
  op_e               s_op_q;
  logic [SIZE_W-1:0] s_size_q;
  logic [SID_W-1:0]  s_sid_q;

  // Output register.
  logic               o_valid_q;
  status_e            o_status_q;
  logic [SID_W-1:0]   o_id_q;
  logic [EIDX_W-1:0]  o_idx_q;
  logic [PAGES_W-1:0] o_pages_q;
  logic [REFS_W-1:0]  o_refs_q;
  logic               o_rel_q;

  // Segment table. Only the used flags need reset; every other field is
  // written by create before it can be looked up.
  logic [SEGMENTS-1:0] used_q;
  logic [SEGMENTS-1:0] marked_q;
  logic [ID_BITS-1:0]  id_q    [SEGMENTS];
  logic [PAGES_W-1:0]  pages_q [SEGMENTS];
  logic [REFS_W-1:0]   refs_q  [SEGMENTS];
  logic [ID_BITS-1:0]  next_id_q;

  logic advance;
  logic req_fire;

  assign advance     = s_valid_q && (!o_valid_q || rsp_o.ready);
  assign req_i.ready = !s_valid_q || advance;
  assign req_fire    = req_i.valid && req_i.ready;

  // Parallel id compare and free-entry search. Both pick the lowest index.
  logic             hit_any;
  logic [IDX_W-1:0] hit_idx;
  logic             free_any;
  logic [IDX_W-1:0] free_idx;

  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SEGMENTS - 1; i >= 0; i--) begin
      if (used_q[i] && (id_q[i] == ID_BITS'(s_sid_q))) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!used_q[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // Size check and page rounding for create.
  logic                size_bad;
  logic [SIZE_W:0]     size_round;
  logic [PAGES_W-1:0]  pages_calc;

  assign size_bad   = (s_size_q == '0) || (32'(s_size_q) > 32'(REGION_BYTES));
  assign size_round = {1'b0, s_size_q} + (SIZE_W + 1)'(PAGE_BYTES - 1);
  assign pages_calc = PAGES_W'(size_round >> PAGE_SHIFT);

  // Fields of the matched entry.
  logic [PAGES_W-1:0] sel_pages;
  logic [REFS_W-1:0]  sel_refs;
  logic               sel_marked;

  assign sel_pages  = pages_q[hit_idx];
  assign sel_refs   = refs_q[hit_idx];
  assign sel_marked = marked_q[hit_idx];

  // Response and table update for the word in the input register.
  status_e            r_status;
  logic [SID_W-1:0]   r_id;
  logic [IDX_W-1:0]   r_idx;
  logic [PAGES_W-1:0] r_pages;
  logic [REFS_W-1:0]  r_refs;
  logic               r_rel;
  logic               do_create;
  logic               do_refs;
  logic               do_mark;
  logic               do_release;
  logic [REFS_W-1:0]  new_refs;

  always_comb begin
    r_status   = ST_OK;
    r_id       = s_sid_q;
    r_idx      = '0;
    r_pages    = '0;
    r_refs     = '0;
    r_rel      = 1'b0;
    do_create  = 1'b0;
    do_refs    = 1'b0;
    do_mark    = 1'b0;
    do_release = 1'b0;
    new_refs   = sel_refs;
    case (s_op_q)
      OP_CREATE: begin
        r_id = '0;
        if (size_bad) begin
          r_status = ST_BAD_SIZE;
        end else if (!free_any) begin
          r_status = ST_TABLE_FULL;
        end else begin
          r_id      = SID_W'(next_id_q);
          r_idx     = free_idx;
          r_pages   = pages_calc;
          do_create = 1'b1;
        end
      end
      default: begin
        if (!hit_any) begin
          r_status = ST_NOT_FOUND;
        end else begin
          r_idx   = hit_idx;
          r_pages = sel_pages;
          r_refs  = sel_refs;
          case (s_op_q)
            OP_ATTACH: begin
              if (sel_marked) begin
                r_status = ST_MARKED;
              end else if (sel_refs == REFS_MAX) begin
                r_status = ST_COUNT_FULL;
              end else begin
                new_refs = sel_refs + REFS_W'(1);
                do_refs  = 1'b1;
                r_refs   = new_refs;
              end
            end
            OP_DETACH: begin
              if (sel_refs != '0) begin
                new_refs = sel_refs - REFS_W'(1);
                do_refs  = 1'b1;
                r_refs   = new_refs;
                if (sel_marked && (new_refs == '0)) begin
                  do_release = 1'b1;
                  r_rel      = 1'b1;
                end
              end
            end
            OP_UNLINK: begin
              do_mark = 1'b1;
              if (sel_refs == '0) begin
                do_release = 1'b1;
                r_rel      = 1'b1;
              end
            end
            default: begin
              r_status = ST_OK;
            end
          endcase
        end
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
      used_q    <= '0;
      next_id_q <= ID_BITS'(1);
    end else begin
      if (req_fire) begin
        s_valid_q <= 1'b1;
      end else if (advance) begin
        s_valid_q <= 1'b0;
      end
      if (advance) begin
        o_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        o_valid_q <= 1'b0;
      end
      if (advance && do_create) begin
        used_q[free_idx] <= 1'b1;
        next_id_q        <= (next_id_q == ID_MAX) ? ID_BITS'(1) : next_id_q + ID_BITS'(1);
      end
      if (advance && do_release) begin
        used_q[hit_idx] <= 1'b0;
      end
    end
  end

  // Payload registers and table fields.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s_op_q   <= op_e'(req_i.op);
      s_size_q <= req_i.size_bytes;
      s_sid_q  <= req_i.seg_id;
    end
    if (advance) begin
      o_status_q <= r_status;
      o_id_q     <= r_id;
      o_idx_q    <= EIDX_W'(r_idx);
      o_pages_q  <= r_pages;
      o_refs_q   <= r_refs;
      o_rel_q    <= r_rel;
      if (do_create) begin
        id_q[free_idx]     <= next_id_q;
        pages_q[free_idx]  <= pages_calc;
        refs_q[free_idx]   <= '0;
        marked_q[free_idx] <= 1'b0;
      end
      if (do_refs) begin
        refs_q[hit_idx] <= new_refs;
      end
      if (do_mark) begin
        marked_q[hit_idx] <= 1'b1;
      end
    end
  end

  assign rsp_o.valid       = o_valid_q;
  assign rsp_o.status      = o_status_q;
  assign rsp_o.result_id   = o_id_q;
  assign rsp_o.entry_index = o_idx_q;
  assign rsp_o.pages       = o_pages_q;
  assign rsp_o.refs        = o_refs_q;
  assign rsp_o.released    = o_rel_q;

endmodule

/* src/rsts_chk.sv */
module rsts_chk
  import rsts_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic [STAT_W-1:0]  status_i,
  input logic [SID_W-1:0]   result_id_i,
  input logic [PAGES_W-1:0] pages_i,
  input logic [REFS_W-1:0]  refs_i,
  input logic               released_i
);

  // A stalled response word holds its contents.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(result_id_i) && $stable(status_i))
    else $error("response word changed while stalled");

  // A release only comes with success and a zero count.
  a_release_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && released_i |-> (status_i == ST_OK) && (refs_i == '0))
    else $error("release flagged on a failed or referenced segment");

  // A refused create reports no segment.
  a_create_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && ((status_i == ST_BAD_SIZE) || (status_i == ST_TABLE_FULL))
      |-> (result_id_i == '0) && (pages_i == '0) && !released_i)
    else $error("failed create reports a segment");

  // Id zero is never handed out, so a successful request never shows it.
  a_ok_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ST_OK) |-> (result_id_i != '0))
    else $error("successful request reports id zero");

endmodule

bind refcounted_segment_table_core rsts_chk u_rsts_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .status_i    (rsp_o.status),
  .result_id_i (rsp_o.result_id),
  .pages_i     (rsp_o.pages),
  .refs_i      (rsp_o.refs),
  .released_i  (rsp_o.released)
);

/* tb/sv/seg_table_check.sv */
module seg_table_check
  import rsts_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  rsts_req_if  req_i,
  rsts_rsp_if  rsp_i,
  output int   errors_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e            status;
    logic [SID_W-1:0]   result_id;
    logic [EIDX_W-1:0]  entry_index;
    logic [PAGES_W-1:0] pages;
    logic [REFS_W-1:0]  refs;
    logic               released;
  } seg_result_t;

  // Mirror of the segment table.
  logic               seg_used   [SEGMENTS];
  logic [ID_BITS-1:0] seg_id     [SEGMENTS];
  logic [PAGES_W-1:0] seg_pages  [SEGMENTS];
  logic [REFS_W-1:0]  seg_refs   [SEGMENTS];
  logic               seg_marked [SEGMENTS];
  logic [ID_BITS-1:0] id_next;

  seg_result_t due_results[$];
  int          mismatches = 0;

  assign errors_o = mismatches;

  function automatic void free_entry(input int i);
    seg_used[i]   = 1'b0;
    seg_id[i]     = '0;
    seg_pages[i]  = '0;
    seg_refs[i]   = '0;
    seg_marked[i] = 1'b0;
  endfunction

  // Applies one request word to the mirror and returns the response it should give.
  function automatic seg_result_t apply_request(input op_e op, input logic [SIZE_W-1:0] size,
                                                input logic [SID_W-1:0] sid);
    seg_result_t w;
    int          hit;
    w   = '0;
    hit = -1;
    if (op == OP_CREATE) begin
      if (size == 0 || size > REGION_BYTES) begin
        w.status = ST_BAD_SIZE;
        return w;
      end
      for (int i = SEGMENTS - 1; i >= 0; i--) begin
        if (!seg_used[i]) hit = i;
      end
      if (hit < 0) begin
        w.status = ST_TABLE_FULL;
        return w;
      end
      seg_used[hit]   = 1'b1;
      seg_id[hit]     = id_next;
      seg_pages[hit]  = PAGES_W'((32'(size) + PAGE_BYTES - 1) >> PAGE_SHIFT);
      seg_refs[hit]   = '0;
      seg_marked[hit] = 1'b0;
      w.result_id     = SID_W'(id_next);
      w.entry_index   = EIDX_W'(hit);
      w.pages         = seg_pages[hit];
      id_next         = (id_next == '1) ? ID_BITS'(1) : id_next + 1'b1;
      return w;
    end

    // The lowest used entry with a matching id wins.
    for (int i = SEGMENTS - 1; i >= 0; i--) begin
      if (seg_used[i] && seg_id[i] == sid) hit = i;
    end
    w.result_id = sid;
    if (hit < 0) begin
      w.status = ST_NOT_FOUND;
      return w;
    end
    w.entry_index = EIDX_W'(hit);
    w.pages       = seg_pages[hit];

    case (op)
      OP_ATTACH: begin
        if (seg_marked[hit]) begin
          w.status = ST_MARKED;
        end else if (seg_refs[hit] == '1) begin
          w.status = ST_COUNT_FULL;
        end else begin
          seg_refs[hit] = seg_refs[hit] + 1'b1;
        end
      end
      OP_DETACH: begin
        if (seg_refs[hit] != 0) seg_refs[hit] = seg_refs[hit] - 1'b1;
      end
      default: begin
        seg_marked[hit] = 1'b1;
      end
    endcase

    if (op != OP_ATTACH && seg_marked[hit] && seg_refs[hit] == 0) begin
      w.released = 1'b1;
      free_entry(hit);
    end
    w.refs = seg_refs[hit];
    return w;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    seg_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SEGMENTS; i++) free_entry(i);
      id_next = ID_BITS'(1);
      due_results.delete();
      pending_o <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: response word with none expected, got status %0d id %0d",
                   $time, rsp_i.status, rsp_i.result_id);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("status", want.status, rsp_i.status);
          check_field("result_id", want.result_id, rsp_i.result_id);
          check_field("entry_index", want.entry_index, rsp_i.entry_index);
          check_field("pages", want.pages, rsp_i.pages);
          check_field("refs", want.refs, rsp_i.refs);
          check_field("released", want.released, rsp_i.released);
        end
      end
      if (req_i.valid && req_i.ready) begin
        due_results.push_back(apply_request(op_e'(req_i.op), req_i.size_bytes, req_i.seg_id));
      end
      pending_o <= due_results.size();
    end
  end

endmodule

/* tb/sv/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rsts_pkg::*;

  localparam int RANDOM_WORDS = 300;
  localparam int CALM_ROUNDS  = 20;
  localparam int HOLD_CYCLES  = 40;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   words_in_flight;

  rsts_req_if req_if ();
  rsts_rsp_if rsp_if ();

  refcounted_segment_table_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // The checker mirrors the table, predicts every response word and compares.
  seg_table_check u_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_if),
    .rsp_i     (rsp_if),
    .errors_o  (fail_count),
    .pending_o (words_in_flight)
  );

  // Light bookkeeping of the segments the stimulus believes are alive. It only
  // steers the choice of ids and operations; all checking lives in the checker.
  typedef struct {
    logic [SID_W-1:0] id;
    int unsigned      refs;
    bit               marked;
  } seg_note_t;

  seg_note_t          live_segs[$];
  logic [ID_BITS-1:0] id_next = ID_BITS'(1);

  // While calm is set neither side idles. A set hold_rsp asks the receiver to
  // hold off; the receiver clears it when it starts.
  bit calm     = 1'b0;
  bit hold_rsp = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #400us;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver. It stalls about 8 percent of the time, and holds off for a
  // long stretch on request so that the block fills up and stalls its input.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_rsp) begin
        hold_rsp = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        rsp_if.ready <= calm || ($urandom_range(99) >= 8);
      end
    end
  end

  // Offers one request word, with random idle cycles in front of it, and
  // returns at the edge where the block takes it. Valid stays high afterward,
  // so back-to-back words never lower and raise it in the same step.
  task automatic send_word(input op_e op, input logic [SIZE_W-1:0] size,
                           input logic [SID_W-1:0] sid);
    while (!calm && $urandom_range(99) < 8) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.op         <= op;
    req_if.size_bytes <= size;
    req_if.seg_id     <= sid;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // Pauses the sender until every predicted response word has come back. The
  // checker's count is registered, hence the edge before the first look.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (words_in_flight != 0);
  endtask

  // Create request; a create with a legal size and a free entry gets the next id.
  task automatic make_segment(input logic [SIZE_W-1:0] size);
    send_word(OP_CREATE, size, SID_W'($urandom));
    if (size != 0 && size <= REGION_BYTES && live_segs.size() < SEGMENTS) begin
      live_segs.push_back('{id: id_next, refs: 0, marked: 1'b0});
      id_next = (id_next == '1) ? ID_BITS'(1) : id_next + 1'b1;
    end
  endtask

  // Attach, detach or unlink aimed at a live segment, with the bookkeeping
  // following the same rules the block applies.
  task automatic touch_segment(input op_e op, input int k);
    seg_note_t s;
    s = live_segs[k];
    send_word(op, SIZE_W'($urandom), s.id);
    case (op)
      OP_ATTACH: if (!s.marked && s.refs < 65535) s.refs++;
      OP_DETACH: if (s.refs != 0) s.refs--;
      OP_UNLINK: s.marked = 1'b1;
      default: ;
    endcase
    if (op != OP_ATTACH && s.marked && s.refs == 0) live_segs.delete(k);
    else live_segs[k] = s;
  endtask

  // Legal sizes, weighted toward small segments and page boundaries.
  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned r;
    int unsigned pg;
    r  = $urandom_range(99);
    pg = $urandom_range(REGION_PAGES, 1);
    if (r < 40) return SIZE_W'($urandom_range(3 * PAGE_BYTES, 1));
    if (r < 70) return SIZE_W'(pg * PAGE_BYTES - $urandom_range(1, 0));
    return SIZE_W'($urandom_range(REGION_BYTES, 1));
  endfunction

  initial begin : stimulus
    int unsigned pick;
    int          k;
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.op         <= OP_CREATE;
    req_if.size_bytes <= '0;
    req_if.seg_id     <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Sizes of zero, the largest field value and one byte past
    // the region are refused. The first good segment has id 1 and stays alive
    // in the lowest entry.
    send_word(OP_CREATE, SIZE_W'(0), SID_W'(0));
    send_word(OP_CREATE, '1, '1);
    send_word(OP_CREATE, SIZE_W'(REGION_BYTES + 1), SID_W'(0));
    make_segment(SIZE_W'(1));
    make_segment(SIZE_W'(REGION_BYTES));
    make_segment(SIZE_W'(PAGE_BYTES + 1));
    make_segment(SIZE_W'(PAGE_BYTES));
    touch_segment(OP_ATTACH, 1);
    touch_segment(OP_ATTACH, 1);
    // Detach at a count of zero changes nothing.
    touch_segment(OP_DETACH, 2);
    // Unlink with references only marks; a later attach is refused as marked.
    touch_segment(OP_UNLINK, 1);
    touch_segment(OP_ATTACH, 1);
    touch_segment(OP_DETACH, 1);
    // The detach that brings a marked segment to zero releases it.
    touch_segment(OP_DETACH, 1);
    // Lookups that miss: a released id, id zero and the all-ones id.
    send_word(OP_ATTACH, SIZE_W'(0), SID_W'(2));
    send_word(OP_DETACH, SIZE_W'(0), SID_W'(0));
    send_word(OP_UNLINK, '1, '1);
    // Unlink of an unreferenced segment releases it at once.
    touch_segment(OP_UNLINK, 1);
    touch_segment(OP_UNLINK, 1);

    // Fill every entry, ask once more to see the table full, then free all but
    // the anchor segment with id 1.
    while (live_segs.size() < SEGMENTS) make_segment(SIZE_W'(PAGE_BYTES - 1));
    make_segment(SIZE_W'(2 * PAGE_BYTES));
    while (live_segs.size() > 1) touch_segment(OP_UNLINK, live_segs.size() - 1);
    wait_drained();

    // Long stretch without idling on either side: whole segment lifecycles of
    // create, attach, unlink while referenced and the releasing detach.
    calm = 1'b1;
    repeat (CALM_ROUNDS) begin
      make_segment(pick_size());
      k = live_segs.size() - 1;
      touch_segment(OP_ATTACH, k);
      touch_segment(OP_UNLINK, k);
      touch_segment(OP_DETACH, k);
    end
    calm = 1'b0;
    wait_drained();

    // Random part: mostly segment lifecycles on live ids, some refused
    // creates, and a little noise with arbitrary ids.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 100 == 37) hold_rsp = 1'b1;
      if (n % 150 == 149) wait_drained();
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_word(op_e'($urandom_range(3, 1)), SIZE_W'($urandom), SID_W'($urandom));
      end else if (pick < 12) begin
        send_word(OP_CREATE,
                  $urandom_range(1) ? SIZE_W'(0) :
                                      SIZE_W'($urandom_range(24'hFFFFFF, REGION_BYTES + 1)),
                  SID_W'($urandom));
      end else if (pick < 30 || live_segs.size() == 0) begin
        make_segment(pick_size());
      end else begin
        k    = $urandom_range(live_segs.size() - 1);
        pick = $urandom_range(99);
        touch_segment(pick < 40 ? OP_ATTACH : (pick < 75 ? OP_DETACH : OP_UNLINK), k);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/rsts_pkg.sv
src/rsts_if.sv
src/refcounted_segment_table_core.sv
src/rsts_chk.sv
tb/sv/seg_table_check.sv
tb/sv/testbench.sv
